/* rtl/u8e_pkg.sv */
package u8e_pkg;

   // Longest encoding in the original six-byte form.
   localparam int unsigned MaxBytes = 6;

   localparam int unsigned CpWidth  = 31;
   localparam int unsigned LenWidth = 3;
   localparam int unsigned IdxWidth = 3;

   // Largest value for each encoding length.
   localparam logic [CpWidth-1:0] Limit1 = 31'h0000_007F;
   localparam logic [CpWidth-1:0] Limit2 = 31'h0000_07FF;
   localparam logic [CpWidth-1:0] Limit3 = 31'h0000_FFFF;
   localparam logic [CpWidth-1:0] Limit4 = 31'h001F_FFFF;
   localparam logic [CpWidth-1:0] Limit5 = 31'h03FF_FFFF;

   localparam logic [1:0] ContMark = 2'b10;

   // One encoded character: bytes in emission order, lead byte at index 0.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [LenWidth-1:0]      len;
   } enc_item_type;

endpackage

/* rtl/u8e_ser.sv */
module u8e_ser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  u8e_pkg::enc_item_type in_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // byte_value
   output logic                  rsp_tlast,   // is_last
   output logic [2:0]            rsp_tuser    // total_length
);

   logic                             valid_ff, valid_in;
   logic [u8e_pkg::IdxWidth-1:0]     idx_ff, idx_in;
   u8e_pkg::enc_item_type            item_ff, item_in;
   logic                             last_byte;
   logic                             take;

   assign last_byte  = (idx_ff == (item_ff.len - 3'd1));
   assign in_ready   = !valid_ff || (rsp_tready && last_byte);
   assign take       = in_valid && in_ready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.bytes[idx_ff];
   assign rsp_tlast  = last_byte;
   assign rsp_tuser  = item_ff.len;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         idx_in   = '0;
         item_in  = in_item;
      end else if (valid_ff && rsp_tready) begin
         if (last_byte) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      item_ff <= item_in;
   end

   // A taken byte that is not the last one is followed by another byte.
   a_more_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("byte stream of a character broke off early");

   // The byte index never runs past the encoding length.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff < item_ff.len))
      else $error("byte index beyond encoding length");

   // Every held character has a length between one and six bytes.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (item_ff.len != 3'd0 && item_ff.len <= 3'd6))
      else $error("encoding length out of range");

endmodule

/* rtl/utf8_encoder.sv */
// Channel   Direction  Ports                    Contents
// req_      in         tvalid tready tdata[31:0] code_point in bits 30:0
// rsp_      out        tvalid tready tdata[7:0]  byte_value; tlast = is_last;
//                                               tuser[2:0] = total_length
//
// A character leaves as 1 to 6 bytes, one byte per cycle on the response
// port while rsp_tready is high, and the next character follows its last
// byte without a gap.
// A request passes stages 1, 2 and 3 and then the serializer register before its first byte appears.
// Reset is synchronous and clears only the valid bits of the stages and of the
// serializer and the byte index of the serializer.
// A stall on the response side holds every full stage; requests keep flowing
// in until all stages are full, and nothing is dropped or repeated.
module utf8_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // code_point [30:0], zero [31]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // byte_value [7:0]
   output logic        rsp_tlast,   // is_last
   output logic [2:0]  rsp_tuser    // total_length [2:0]
);

   // Stage 1 captures the request, stage 2 finds the encoding length,
   // stage 3 builds all bytes, and the serializer sends them one by one.
   logic                                 v1_ff, v2_ff, v3_ff;
   logic [u8e_pkg::CpWidth-1:0]          cp1_ff, cp2_ff;
   logic [u8e_pkg::LenWidth-1:0]         len2_ff, len2_in;
   u8e_pkg::enc_item_type                enc3_ff, enc3_in;
   logic                                 rdy1, rdy2, rdy3;
   logic                                 ser_ready;

   // Each stage loads when empty or when its content moves on.
   assign rdy3       = !v3_ff || ser_ready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   // Length is the smallest that holds the value.
   always_comb begin
      if (cp1_ff > u8e_pkg::Limit5) begin
         len2_in = 3'd6;
      end else if (cp1_ff > u8e_pkg::Limit4) begin
         len2_in = 3'd5;
      end else if (cp1_ff > u8e_pkg::Limit3) begin
         len2_in = 3'd4;
      end else if (cp1_ff > u8e_pkg::Limit2) begin
         len2_in = 3'd3;
      end else if (cp1_ff > u8e_pkg::Limit1) begin
         len2_in = 3'd2;
      end else begin
         len2_in = 3'd1;
      end
   end

   // Six-bit payload groups of the value, group 0 in the lowest bits.
   logic [u8e_pkg::MaxBytes-1:0][5:0] chunk;
   logic [u8e_pkg::LenWidth-1:0]      src;

   assign chunk = {5'd0, cp2_ff};

   always_comb begin
      enc3_in       = '0;
      enc3_in.len   = len2_ff;
      src           = '0;
      // A multi-byte lead byte carries length ones, a zero and the top payload bits.
      case (len2_ff)
         3'd1:    enc3_in.bytes[0] = {1'b0, cp2_ff[6:0]};
         3'd2:    enc3_in.bytes[0] = {3'b110, cp2_ff[10:6]};
         3'd3:    enc3_in.bytes[0] = {4'b1110, cp2_ff[15:12]};
         3'd4:    enc3_in.bytes[0] = {5'b11110, cp2_ff[20:18]};
         3'd5:    enc3_in.bytes[0] = {6'b111110, cp2_ff[25:24]};
         3'd6:    enc3_in.bytes[0] = {7'b1111110, cp2_ff[30]};
         default: enc3_in.bytes[0] = '0;
      endcase
      // Continuation bytes take the lower groups, highest group first.
      for (int k = 1; k < u8e_pkg::MaxBytes; k++) begin
         if (3'(k) < len2_ff) begin
            src = len2_ff - 3'd1 - 3'(k);
            enc3_in.bytes[k] = {u8e_pkg::ContMark, chunk[src]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
      if (rdy1) cp1_ff <= req_tdata[u8e_pkg::CpWidth-1:0];
      if (rdy2) begin
         cp2_ff  <= cp1_ff;
         len2_ff <= len2_in;
      end
      if (rdy3) enc3_ff <= enc3_in;
   end

   u8e_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v3_ff),
      .in_ready   (ser_ready),
      .in_item    (enc3_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A full stage that cannot move on keeps its valid bit.
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> v2_ff)
      else $error("stage two lost a request under stall");

   // The last stage keeps its character until the serializer takes it.
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ser_ready) |=> v3_ff)
      else $error("stage three lost a request under stall");

   // Only ASCII values get a one-byte encoding.
   a_len_one: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && len2_ff == 3'd1) |-> (cp2_ff <= u8e_pkg::Limit1))
      else $error("one-byte length for a value above ASCII");

endmodule
